// ===== hw/rtl/fltr_pkg.sv =====
package fltr_pkg;

    // Default sizes, handed to the top-level parameters
    localparam int FRAMES_DEF     = 4;
    localparam int PAGE_BITS_DEF  = 8;
    localparam int COUNT_BITS_DEF = 16;

    // Fixed widths of the configuration fields
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 3;
    localparam int FIU_BITS       = 3;

    // Register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_POLICY        = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAMES_IN_USE = 1'b1;

    // Replacement policies
    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    // Input operations, carried on tuser
    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // Reset values of the registers
    localparam logic                POLICY_RESET = POLICY_FIFO;
    localparam logic [FIU_BITS-1:0] FIU_RESET    = 3'd4;

    // Output tuser bit positions
    localparam int UB_HIT     = 0;
    localparam int UB_FAULT   = 1;
    localparam int UB_EVICTED = 2;
    localparam int USER_BITS  = 3;

    // Priority flags carried from the lowest cell upward
    typedef struct packed {
        logic hit_seen;
        logic empty_seen;
    } chain_fwd_t;

    // Per-transaction command broadcast to every cell
    typedef struct packed {
        logic access;
        logic clear;
        logic lru;
        logic hit_any;
        logic empty_any;
    } cell_cmd_t;

endpackage

// ===== hw/rtl/fltr_cell.sv =====
module fltr_cell
    import fltr_pkg::*;
#(
    parameter int PAGE_BITS = PAGE_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cell_cmd_t            cmd,
    input  logic [PAGE_BITS-1:0] page,
    input  logic                 in_use,
    input  logic                 is_last,
    input  chain_fwd_t           fwd_in,
    output chain_fwd_t           fwd_out,
    input  logic                 nonempty_in,
    output logic                 nonempty_out,
    input  logic [PAGE_BITS-1:0] upper_frame,
    output logic [PAGE_BITS-1:0] frame
);

    logic [PAGE_BITS-1:0] frame_reg;
    logic [PAGE_BITS-1:0] frame_next;
    logic                 match;
    logic                 empty;
    logic                 occupied;
    logic                 first_empty;
    logic                 from_hit;
    logic                 is_top;

    // Local compare against the referenced page
    assign match    = in_use && (frame_reg == page);
    assign empty    = in_use && (frame_reg == '0);
    assign occupied = in_use && (frame_reg != '0);

    // Priority chains: lowest hit and lowest empty frame upward, occupancy downward
    assign fwd_out.hit_seen   = fwd_in.hit_seen | match;
    assign fwd_out.empty_seen = fwd_in.empty_seen | empty;
    assign nonempty_out       = nonempty_in | occupied;

    assign first_empty = empty && !fwd_in.empty_seen;
    assign from_hit    = fwd_out.hit_seen;
    // most-recent position: highest occupied frame in use
    assign is_top      = occupied && !nonempty_in;

    // Next frame value
    always_comb
    begin
        frame_next = frame_reg;
        if (cmd.clear)
        begin
            frame_next = '0;
        end
        else if (cmd.access)
        begin
            if (cmd.hit_any)
            begin
                if (cmd.lru && from_hit)
                begin
                    if (nonempty_in)
                        frame_next = upper_frame;
                    else if (is_top)
                        frame_next = page;
                end
            end
            else if (cmd.empty_any)
            begin
                if (first_empty)
                    frame_next = page;
            end
            else if (in_use)
            begin
                // eviction: shift down, new page into the last frame in use
                frame_next = is_last ? page : upper_frame;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            frame_reg <= '0;
        else
            frame_reg <= frame_next;
    end

    assign frame = frame_reg;

endmodule

// ===== hw/rtl/fifo_lru_page_frame_tracker.sv =====
// A result is captured in the output register in the cycle after its transaction is accepted.
// The block takes one transaction per cycle while not stalled; the frame cells compare and shift in one step,
// so the chain of FRAMES cells sets the cycle's logic depth.
// The input stalls only while a result waits in the output register and is not taken.
// Reset (rst_n low, asynchronous): all frames empty, fault count zero,
// policy first-in first-out, frames in use 4, output empty.
module fifo_lru_page_frame_tracker
    import fltr_pkg::*;
#(
    parameter int FRAMES     = FRAMES_DEF,
    parameter int PAGE_BITS  = PAGE_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    localparam int IN_W      = ((PAGE_BITS + 7) / 8) * 8,
    localparam int OUT_W     = ((PAGE_BITS + COUNT_BITS + 7) / 8) * 8
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    // input stream
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [IN_W-1:0]           s_axis_tdata,  // [PAGE_BITS-1:0] page
    input  logic                      s_axis_tuser,  // operation
    input  logic                      s_axis_tlast,  // last_access
    // result stream
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [OUT_W-1:0]          m_axis_tdata,  // evicted_page, fault_count
    output logic [USER_BITS-1:0]      m_axis_tuser,  // hit, fault, evicted_valid
    output logic                      m_axis_tlast   // total_ready
);

    localparam int FC_BITS = $clog2(FRAMES + 1);
    localparam int N_BITS  = (FC_BITS > FIU_BITS) ? FC_BITS : FIU_BITS;

    logic                  policy_reg;
    logic [FIU_BITS-1:0]   fiu_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  m_valid_reg;
    logic [OUT_W-1:0]      m_data_reg;
    logic [USER_BITS-1:0]  m_user_reg;
    logic                  m_last_reg;

    logic                  accept;
    logic                  is_clear;
    logic                  is_access;
    logic [PAGE_BITS-1:0]  page;
    logic [N_BITS-1:0]     fiu_ext;
    logic [N_BITS-1:0]     n_used;
    logic                  miss;
    logic                  evict;
    logic [PAGE_BITS-1:0]  evicted_page;
    cell_cmd_t             cmd;

    chain_fwd_t            fwd [FRAMES+1];
    logic                  nonempty [FRAMES+1];
    logic [PAGE_BITS-1:0]  frame [FRAMES+1];

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POLICY_RESET;
            fiu_reg    <= FIU_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_POLICY:        policy_reg <= cfg_data[0];
                REG_FRAMES_IN_USE: fiu_reg    <= cfg_data[FIU_BITS-1:0];
                default:           ;
            endcase
        end
    end

    // Frames in use, clamped to 1..FRAMES
    assign fiu_ext = N_BITS'(fiu_reg);
    always_comb
    begin
        if (fiu_ext == '0)
            n_used = N_BITS'(1);
        else if (fiu_ext > N_BITS'(FRAMES))
            n_used = N_BITS'(FRAMES);
        else
            n_used = fiu_ext;
    end

    // Input decode
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign page          = s_axis_tdata[PAGE_BITS-1:0];
    assign is_clear      = (s_axis_tuser == OP_CLEAR);
    assign is_access     = (s_axis_tuser == OP_ACCESS) && (page != '0);

    assign cmd.access    = accept && is_access;
    assign cmd.clear     = accept && is_clear;
    assign cmd.lru       = (policy_reg == POLICY_LRU);
    assign cmd.hit_any   = fwd[FRAMES].hit_seen;
    assign cmd.empty_any = fwd[FRAMES].empty_seen;

    // Chain ends
    assign fwd[0].hit_seen   = 1'b0;
    assign fwd[0].empty_seen = 1'b0;
    assign nonempty[FRAMES]  = 1'b0;
    assign frame[FRAMES]     = '0;

    // Row of frame cells
    for (genvar i = 0; i < FRAMES; i++)
    begin : g_cell
        fltr_cell #(
            .PAGE_BITS (PAGE_BITS)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .cmd          (cmd),
            .page         (page),
            .in_use       (n_used > N_BITS'(i)),
            .is_last      (n_used == N_BITS'(i + 1)),
            .fwd_in       (fwd[i]),
            .fwd_out      (fwd[i+1]),
            .nonempty_in  (nonempty[i+1]),
            .nonempty_out (nonempty[i]),
            .upper_frame  (frame[i+1]),
            .frame        (frame[i])
        );
    end

    // Fault accounting
    assign miss         = is_access && !cmd.hit_any;
    assign evict        = miss && !cmd.empty_any;
    assign evicted_page = evict ? frame[0] : '0;

    always_comb
    begin
        count_next = count_reg;
        if (is_clear)
            count_next = '0;
        else if (miss && (count_reg != '1))
            count_next = count_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (accept)
            count_reg <= count_next;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (accept)
            m_valid_reg <= 1'b1;
        else if (m_axis_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_data_reg              <= OUT_W'({count_next, evicted_page});
            m_user_reg[UB_HIT]      <= is_access && cmd.hit_any;
            m_user_reg[UB_FAULT]    <= miss;
            m_user_reg[UB_EVICTED]  <= evict;
            m_last_reg              <= s_axis_tlast;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;
    assign m_axis_tlast  = m_last_reg;

    // Checks
    a_hit_xor_fault: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> !(m_user_reg[UB_HIT] && m_user_reg[UB_FAULT]))
        else $error("hit and fault reported together");

    a_evict_is_fault: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && m_user_reg[UB_EVICTED] |-> m_user_reg[UB_FAULT])
        else $error("eviction without a fault");

    a_evict_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        accept && evict |-> (frame[0] != '0))
        else $error("evicted an empty frame");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !is_clear |=>
            (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + 1'b1))
        else $error("fault count moved by more than one");

    a_idle_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
        else $error("fault count changed without a transaction");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import fltr_pkg::*;

    localparam int PAGE_W     = PAGE_BITS_DEF;
    localparam int COUNT_W    = COUNT_BITS_DEF;
    localparam int IN_W       = ((PAGE_W + 7) / 8) * 8;
    localparam int OUT_W      = ((PAGE_W + COUNT_W + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 600000;
    localparam int MAX_REPORTS = 40;

    // One result transaction, as the block should produce it
    typedef struct packed {
        logic               hit;
        logic               fault;
        logic               ev_valid;
        logic [PAGE_W-1:0]  ev_page;
        logic [COUNT_W-1:0] fault_count;
        logic               total_ready;
    } page_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata = '0;   // [7:0] page
    logic                 s_axis_tuser = 1'b0; // operation
    logic                 s_axis_tlast = 1'b0; // last_access

    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     m_axis_tdata;        // [7:0] evicted_page, [23:8] fault_count
    logic [USER_BITS-1:0] m_axis_tuser;        // [0] hit, [1] fault, [2] evicted_valid
    logic                 m_axis_tlast;        // total_ready

    // Shadow of the tracker state and registers
    logic [PAGE_W-1:0]  frame_tab [FRAMES_DEF];
    logic [COUNT_W-1:0] fault_tally = '0;
    logic               cur_policy = POLICY_RESET;
    logic [FIU_BITS-1:0] cur_fiu = FIU_RESET;

    page_result_t pending_results [$];

    int  err_count = 0;
    int  cycle_count = 0;
    bit  jitter_on = 1'b1;
    int  rx_hold_req = 0;
    int  rx_hold_left = 0;

    fifo_lru_page_frame_tracker dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Work out the result of one accepted transaction and update the shadow state
    task automatic predict_ref(input logic op, input logic [PAGE_W-1:0] pg, input logic last);
        page_result_t r;
        int n;
        int hit_at;
        int empty_at;
        int top;
        r = '0;
        r.total_ready = last;
        n = (cur_fiu < 1) ? 1 : ((cur_fiu > FRAMES_DEF) ? FRAMES_DEF : int'(cur_fiu));
        if (op == OP_CLEAR)
        begin
            foreach (frame_tab[i])
                frame_tab[i] = '0;
            fault_tally = '0;
        end
        else if (pg != '0)
        begin
            hit_at = -1;
            empty_at = -1;
            for (int i = 0; i < n; i++)
            begin
                if (hit_at < 0 && frame_tab[i] == pg)
                    hit_at = i;
                if (empty_at < 0 && frame_tab[i] == '0)
                    empty_at = i;
            end
            if (hit_at >= 0)
            begin
                r.hit = 1'b1;
                if (cur_policy == POLICY_LRU)
                begin
                    // most-recent slot is the last occupied frame in use
                    top = hit_at;
                    for (int i = 0; i < n; i++)
                        if (frame_tab[i] != '0)
                            top = i;
                    for (int i = hit_at; i < top; i++)
                        frame_tab[i] = frame_tab[i+1];
                    frame_tab[top] = pg;
                end
            end
            else
            begin
                r.fault = 1'b1;
                if (fault_tally != '1)
                    fault_tally++;
                if (empty_at >= 0)
                    frame_tab[empty_at] = pg;
                else
                begin
                    r.ev_valid = 1'b1;
                    r.ev_page = frame_tab[0];
                    for (int i = 0; i + 1 < n; i++)
                        frame_tab[i] = frame_tab[i+1];
                    frame_tab[n-1] = pg;
                end
            end
        end
        r.fault_count = fault_tally;
        pending_results.push_back(r);
    endtask

    // Offer one input transaction; valid stays high afterwards until the next gap
    task automatic send_ref(input logic op, input logic [PAGE_W-1:0] pg, input logic last);
        if (jitter_on && $urandom_range(99) < 27)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 40);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'(pg);
        s_axis_tuser  <= op;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_ref(op, pg, last);
    endtask

    // Stop offering and wait for every outstanding result
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_POLICY)
            cur_policy = val[0];
        else
            cur_fiu = val;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic void report_mismatch(input string what, input longint want,
                                            input longint got);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("%0t ns: %s expected %0d, actual %0d", $time, what, want, got);
    endfunction

    // Result side: random ready, long hold on request, and the field checks
    always @(posedge clk)
    begin : result_side
        page_result_t want;
        if (rx_hold_req > 0)
        begin
            rx_hold_left = rx_hold_req;
            rx_hold_req = 0;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("%0t ns: result transaction with none expected, tdata %0h",
                             $time, m_axis_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tuser[UB_HIT] !== want.hit)
                    report_mismatch("hit", want.hit, m_axis_tuser[UB_HIT]);
                if (m_axis_tuser[UB_FAULT] !== want.fault)
                    report_mismatch("fault", want.fault, m_axis_tuser[UB_FAULT]);
                if (m_axis_tuser[UB_EVICTED] !== want.ev_valid)
                    report_mismatch("evicted_valid", want.ev_valid, m_axis_tuser[UB_EVICTED]);
                if (m_axis_tdata[PAGE_W-1:0] !== want.ev_page)
                    report_mismatch("evicted_page", want.ev_page, m_axis_tdata[PAGE_W-1:0]);
                if (m_axis_tdata[PAGE_W +: COUNT_W] !== want.fault_count)
                    report_mismatch("fault_count", want.fault_count,
                                    m_axis_tdata[PAGE_W +: COUNT_W]);
                if (m_axis_tlast !== want.total_ready)
                    report_mismatch("total_ready", want.total_ready, m_axis_tlast);
            end
        end
        if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= !(jitter_on && $urandom_range(99) < 27);
    end

    // Reset defaults, FIFO fill, hits without movement, eviction order, page zero, clear
    task automatic test_fifo_basics();
        send_ref(OP_ACCESS, 8'd1, 1'b0);
        send_ref(OP_ACCESS, 8'd255, 1'b0);
        send_ref(OP_ACCESS, 8'd0, 1'b1);
        send_ref(OP_ACCESS, 8'd1, 1'b0);
        send_ref(OP_ACCESS, 8'd128, 1'b0);
        send_ref(OP_ACCESS, 8'd127, 1'b0);
        send_ref(OP_ACCESS, 8'd200, 1'b0);
        send_ref(OP_ACCESS, 8'd255, 1'b0);
        send_ref(OP_ACCESS, 8'd9, 1'b1);
        send_ref(OP_CLEAR, 8'd170, 1'b1);
        send_ref(OP_ACCESS, 8'd0, 1'b0);
    endtask

    // LRU: hit with empty frames behind, hit moving to the top, eviction after
    task automatic test_lru_hits();
        write_reg(REG_POLICY, CFG_DATA_BITS'(POLICY_LRU));
        send_ref(OP_CLEAR, 8'd0, 1'b0);
        send_ref(OP_ACCESS, 8'd10, 1'b0);
        send_ref(OP_ACCESS, 8'd20, 1'b0);
        send_ref(OP_ACCESS, 8'd10, 1'b0);
        send_ref(OP_ACCESS, 8'd30, 1'b0);
        send_ref(OP_ACCESS, 8'd40, 1'b0);
        send_ref(OP_ACCESS, 8'd10, 1'b0);
        send_ref(OP_ACCESS, 8'd50, 1'b1);
    endtask

    // Frame count out of range, changed mid-trace, duplicate pages
    task automatic test_frame_counts();
        write_reg(REG_POLICY, CFG_DATA_BITS'(POLICY_FIFO));
        write_reg(REG_FRAMES_IN_USE, 3'd0);
        send_ref(OP_CLEAR, 8'd0, 1'b0);
        send_ref(OP_ACCESS, 8'd3, 1'b0);
        send_ref(OP_ACCESS, 8'd4, 1'b0);
        write_reg(REG_FRAMES_IN_USE, 3'd7);
        send_ref(OP_ACCESS, 8'd5, 1'b0);
        write_reg(REG_FRAMES_IN_USE, 3'd1);
        send_ref(OP_ACCESS, 8'd5, 1'b0);
        write_reg(REG_FRAMES_IN_USE, 3'd5);
        write_reg(REG_POLICY, CFG_DATA_BITS'(POLICY_LRU));
        send_ref(OP_ACCESS, 8'd5, 1'b0);
        send_ref(OP_ACCESS, 8'd6, 1'b1);
    endtask

    // Receiver holds off while the sender keeps offering, then a full drain
    task automatic test_backpressure();
        write_reg(REG_FRAMES_IN_USE, 3'd3);
        rx_hold_req = 300;
        for (int k = 0; k < 40; k++)
            send_ref(OP_ACCESS, PAGE_W'($urandom_range(1, 6)), k == 39);
        wait_drained();
    endtask

    // Every access faults with a single frame; the count climbs by one each time
    task automatic test_fault_count_single_frame();
        write_reg(REG_POLICY, CFG_DATA_BITS'(POLICY_FIFO));
        write_reg(REG_FRAMES_IN_USE, 3'd1);
        jitter_on = 1'b0;
        send_ref(OP_CLEAR, 8'd0, 1'b0);
        for (int k = 0; k < 36; k++)
            send_ref(OP_ACCESS, PAGE_W'(1 + (k & 1)), 1'($urandom_range(1)));
        send_ref(OP_CLEAR, 8'd0, 1'b1);
        jitter_on = 1'b1;
    endtask

    // Mostly well-formed reference traces over a small page pool, plus noise
    task automatic test_random_traces();
        logic [FIU_BITS-1:0] fiu_plan [10] = '{3'd4, 3'd1, 3'd2, 3'd3, 3'd0,
                                               3'd5, 3'd4, 3'd7, 3'd2, 3'd4};
        int sent;
        int pool;
        int base;
        int len;
        int roll;
        logic [PAGE_W-1:0] pg;
        logic last;
        for (int ph = 0; ph < 10; ph++)
        begin
            write_reg(REG_POLICY, CFG_DATA_BITS'(ph % 2));
            write_reg(REG_FRAMES_IN_USE, CFG_DATA_BITS'(fiu_plan[ph]));
            jitter_on = (ph != 6);
            sent = 0;
            while (sent < 150)
            begin
                pool = $urandom_range(2, 9);
                base = $urandom_range(1, 246);
                if ($urandom_range(99) < 60)
                begin
                    send_ref(OP_CLEAR, PAGE_W'($urandom), 1'($urandom_range(1)));
                    sent++;
                end
                len = $urandom_range(2, 30);
                for (int k = 0; k < len; k++)
                begin
                    roll = $urandom_range(99);
                    last = (k == len - 1) || ($urandom_range(99) < 3);
                    if (roll < 85)
                        pg = PAGE_W'(base + $urandom_range(0, pool - 1));
                    else if (roll < 93)
                        pg = PAGE_W'($urandom_range(1, 255));
                    else
                        pg = '0;
                    if (roll >= 97)
                        send_ref(OP_CLEAR, PAGE_W'($urandom), last);
                    else
                        send_ref(OP_ACCESS, pg, last);
                    sent++;
                end
            end
        end
        jitter_on = 1'b1;
    endtask

    initial
    begin
        foreach (frame_tab[i])
            frame_tab[i] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_fifo_basics();
        test_lru_hits();
        test_frame_counts();
        test_backpressure();
        test_fault_count_single_frame();
        test_random_traces();
        wait_drained();
        repeat (8) @(posedge clk);
        if (err_count == 0 && pending_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
